[sv/drodo_pkg.sv]
// Shared constants, opcodes and the quarter-wave sine table for the odometry core.
// Used by the channel interfaces, the trig and report lanes and the top level.
// Depends on nothing.
package drodo_pkg;

    localparam int POS_W      = 48;
    localparam int REP_W      = 32;
    localparam int HEAD_W     = 9;
    localparam int TURN_W     = 10;
    localparam int OP_W       = 2;
    localparam int TRIG_IDX_W = 7;
    localparam int TRIG_Q_W   = 16;

    // A position magnitude times one hundred fits in this many bits.
    localparam int NUM_W      = POS_W + 7;
    // Quotient bits developed serially; a larger quotient saturates the report.
    localparam int QUO_BITS   = REP_W - 1;

    localparam int QUARTER_TURN       = 90;
    localparam int HALF_TURN          = 180;
    localparam int THREE_QUARTER_TURN = 270;
    localparam int FULL_TURN          = 360;

    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
    localparam logic [OP_W-1:0] OP_COMMIT = 2'd1;
    localparam logic [OP_W-1:0] OP_TURN   = 2'd2;

    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic signed [REP_W-1:0] REP_MAX = {1'b0, {(REP_W-1){1'b1}}};
    localparam logic signed [REP_W-1:0] REP_MIN = {1'b1, {(REP_W-1){1'b0}}};

    localparam logic [TRIG_Q_W-1:0] SIN_Q15_TAB [0:90] = '{
        16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,  16'd2856,  16'd3425,
        16'd3993,  16'd4560,  16'd5126,  16'd5690,  16'd6252,  16'd6813,  16'd7371,
        16'd7927,  16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668, 16'd11207,
        16'd11743, 16'd12275, 16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876,
        16'd15384, 16'd15886, 16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
        16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498,
        16'd21926, 16'd22348, 16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351,
        16'd24730, 16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842,
        16'd27166, 16'd27482, 16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932,
        16'd29197, 16'd29452, 16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
        16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795,
        16'd31928, 16'd32052, 16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524,
        16'd32588, 16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32768
    };

    // Indexes past a quarter turn read the top entry.
    function automatic logic [TRIG_Q_W-1:0] sin_q15(input logic [TRIG_IDX_W-1:0] idx);
        logic [TRIG_IDX_W-1:0] i;
        i = (idx > TRIG_IDX_W'(QUARTER_TURN)) ? TRIG_IDX_W'(QUARTER_TURN) : idx;
        return SIN_Q15_TAB[i];
    endfunction

endpackage

[sv/drodo_if.sv]
// Valid/ready channel interfaces for the odometry core: one for input items, one for results.
// Depends on drodo_pkg for the fixed field widths.
interface drodo_item_if #(
    parameter int ENCODER_BITS = 24
) ();
    logic                                 valid;
    logic                                 ready;
    logic [drodo_pkg::OP_W-1:0]           opcode;
    logic signed [ENCODER_BITS-1:0]       left_count;
    logic signed [ENCODER_BITS-1:0]       right_count;
    logic signed [drodo_pkg::TURN_W-1:0]  turn_angle;

    modport source (output valid, output opcode, output left_count, output right_count,
                    output turn_angle, input ready);
    modport sink   (input valid, input opcode, input left_count, input right_count,
                    input turn_angle, output ready);
endinterface

interface drodo_result_if ();
    logic                                valid;
    logic                                ready;
    logic signed [drodo_pkg::REP_W-1:0]  pos_x_hundredths;
    logic signed [drodo_pkg::REP_W-1:0]  pos_y_hundredths;
    logic [drodo_pkg::HEAD_W-1:0]        heading_deg;

    modport source (output valid, output pos_x_hundredths, output pos_y_hundredths,
                    output heading_deg, input ready);
    modport sink   (input valid, input pos_x_hundredths, input pos_y_hundredths,
                    input heading_deg, output ready);
endinterface

[sv/drodo_trig.sv]
// Sine and cosine of the whole-degree heading, as sign and magnitude with a chosen fraction.
// Depends on drodo_pkg for the quarter-wave table; outputs are registered every cycle.
module drodo_trig #(
    parameter int TRIG_FRAC_BITS = 15
) (
    input  logic                              i_clk,
    input  logic [drodo_pkg::HEAD_W-1:0]      i_heading,
    output logic [TRIG_FRAC_BITS:0]           o_sin_mag,
    output logic                              o_sin_neg,
    output logic [TRIG_FRAC_BITS:0]           o_cos_mag,
    output logic                              o_cos_neg
);

    localparam int MAG_W = TRIG_FRAC_BITS + 1;
    localparam int ANG_W = drodo_pkg::HEAD_W + 1;

    typedef struct packed {
        logic                               neg;
        logic [drodo_pkg::TRIG_IDX_W-1:0]   idx;
    } t_quad;

    // Folds an angle in 0..359 onto the first quadrant.
    function automatic t_quad fold(input logic [ANG_W-1:0] h);
        t_quad q;
        if (h <= ANG_W'(drodo_pkg::QUARTER_TURN)) begin
            q.neg = 1'b0;
            q.idx = drodo_pkg::TRIG_IDX_W'(h);
        end else if (h <= ANG_W'(drodo_pkg::HALF_TURN)) begin
            q.neg = 1'b0;
            q.idx = drodo_pkg::TRIG_IDX_W'(ANG_W'(drodo_pkg::HALF_TURN) - h);
        end else if (h <= ANG_W'(drodo_pkg::THREE_QUARTER_TURN)) begin
            q.neg = 1'b1;
            q.idx = drodo_pkg::TRIG_IDX_W'(h - ANG_W'(drodo_pkg::HALF_TURN));
        end else begin
            q.neg = 1'b1;
            q.idx = drodo_pkg::TRIG_IDX_W'(ANG_W'(drodo_pkg::FULL_TURN) - h);
        end
        return q;
    endfunction

    logic [ANG_W-1:0]               sin_ang;
    logic [ANG_W-1:0]               cos_ang;
    t_quad                          sin_q;
    t_quad                          cos_q;
    logic [drodo_pkg::TRIG_Q_W-1:0] sin_raw;
    logic [drodo_pkg::TRIG_Q_W-1:0] cos_raw;
    logic [MAG_W-1:0]               sin_mag_c;
    logic [MAG_W-1:0]               cos_mag_c;

    always_comb begin
        sin_ang = ANG_W'(i_heading);
        cos_ang = sin_ang + ANG_W'(drodo_pkg::QUARTER_TURN);
        if (cos_ang >= ANG_W'(drodo_pkg::FULL_TURN)) begin
            cos_ang = cos_ang - ANG_W'(drodo_pkg::FULL_TURN);
        end
        sin_q   = fold(sin_ang);
        cos_q   = fold(cos_ang);
        sin_raw = drodo_pkg::sin_q15(sin_q.idx);
        cos_raw = drodo_pkg::sin_q15(cos_q.idx);
    end

    generate
        if (TRIG_FRAC_BITS >= 15) begin : g_widen
            localparam int SH = TRIG_FRAC_BITS - 15;
            assign sin_mag_c = MAG_W'(sin_raw) << SH;
            assign cos_mag_c = MAG_W'(cos_raw) << SH;
        end else begin : g_narrow
            // Rounds half up on the magnitude while dropping fraction bits.
            localparam int SH = 15 - TRIG_FRAC_BITS;
            localparam logic [drodo_pkg::TRIG_Q_W:0] HALF =
                (drodo_pkg::TRIG_Q_W+1)'(1) << (SH - 1);
            assign sin_mag_c = MAG_W'(((drodo_pkg::TRIG_Q_W+1)'(sin_raw) + HALF) >> SH);
            assign cos_mag_c = MAG_W'(((drodo_pkg::TRIG_Q_W+1)'(cos_raw) + HALF) >> SH);
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        o_sin_mag <= sin_mag_c;
        o_sin_neg <= sin_q.neg;
        o_cos_mag <= cos_mag_c;
        o_cos_neg <= cos_q.neg;
    end

endmodule

[sv/drodo_mul.sv]
// Serial-parallel multiplier lane: signed travel times a trig magnitude, one bit per cycle.
// Depends on nothing but its parameters; the sign is applied in a final step after the bits.
module drodo_mul #(
    parameter int ENCODER_BITS   = 24,
    parameter int TRIG_FRAC_BITS = 15
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_start,
    input  logic signed [ENCODER_BITS-1:0]                i_travel,
    input  logic [TRIG_FRAC_BITS:0]                       i_mag,
    input  logic                                          i_neg,
    output logic                                          o_done,
    output logic signed [ENCODER_BITS+TRIG_FRAC_BITS:0]   o_product
);

    localparam int MAG_W  = TRIG_FRAC_BITS + 1;
    localparam int PROD_W = ENCODER_BITS + TRIG_FRAC_BITS + 1;
    localparam int CNT_W  = $clog2(MAG_W);

    typedef enum logic [2:0] {
        M_IDLE = 3'b001,
        M_RUN  = 3'b010,
        M_SIGN = 3'b100
    } t_mstate;

    t_mstate                     r_state;
    logic                        r_done;
    logic [CNT_W-1:0]            r_cnt;
    logic signed [PROD_W-1:0]    r_acc;
    logic [MAG_W-1:0]            r_mplr;
    logic signed [ENCODER_BITS-1:0] r_mcand;
    logic                        r_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        r_cnt   <= '0;
                        r_state <= M_RUN;
                    end
                end
                M_RUN: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(MAG_W - 1)) begin
                        r_state <= M_SIGN;
                    end
                end
                M_SIGN: begin
                    r_done  <= 1'b1;
                    r_state <= M_IDLE;
                end
                default: r_state <= M_IDLE;
            endcase
        end
    end

    // Multiplier bits are consumed most significant first.
    always_ff @(posedge i_clk) begin
        if (r_state == M_IDLE && i_start) begin
            r_acc   <= '0;
            r_mplr  <= i_mag;
            r_mcand <= i_travel;
            r_neg   <= i_neg;
        end else if (r_state == M_RUN) begin
            r_acc  <= (r_acc <<< 1) + (r_mplr[MAG_W-1] ? PROD_W'(r_mcand) : '0);
            r_mplr <= r_mplr << 1;
        end else if (r_state == M_SIGN && r_neg) begin
            r_acc <= -r_acc;
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

[sv/drodo_div.sv]
// Report lane: position times one hundred, divided by counts per rotation times the trig
// scale, one quotient bit per cycle, truncated toward zero and saturated to 32 bits.
// Depends on drodo_pkg for the position and report widths.
module drodo_div #(
    parameter int COUNTS_PER_REV = 360,
    parameter int TRIG_FRAC_BITS = 15
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [drodo_pkg::POS_W-1:0]  i_pos,
    output logic                                o_done,
    output logic signed [drodo_pkg::REP_W-1:0]  o_value
);

    localparam int POS_W = drodo_pkg::POS_W;
    localparam int NUM_W = drodo_pkg::NUM_W;
    localparam int QB    = drodo_pkg::QUO_BITS;
    localparam int REP_W = drodo_pkg::REP_W;
    localparam logic [63:0] DIVISOR   = 64'(COUNTS_PER_REV) << TRIG_FRAC_BITS;
    localparam logic [63:0] SAT_LIMIT = DIVISOR << QB;
    localparam int DIV_W = $clog2(DIVISOR + 64'd1);
    localparam int CNT_W = $clog2(QB);

    typedef enum logic [4:0] {
        D_IDLE  = 5'b00001,
        D_SCALE = 5'b00010,
        D_INIT  = 5'b00100,
        D_STEP  = 5'b01000,
        D_DONE  = 5'b10000
    } t_dstate;

    t_dstate                  r_state;
    logic                     r_done;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_neg;
    logic                     r_sat;
    logic [POS_W-1:0]         r_mag;
    logic [NUM_W-1:0]         r_num;
    logic [DIV_W-1:0]         r_rem;
    logic [QB-1:0]            r_quo;
    logic signed [REP_W-1:0]  r_val;

    logic [DIV_W:0]           rem2_c;
    logic                     ge_c;
    logic [REP_W-1:0]         quo_ext_c;

    always_comb begin
        rem2_c    = {r_rem, r_num[QB-1]};
        ge_c      = rem2_c >= (DIV_W+1)'(DIVISOR);
        quo_ext_c = REP_W'(r_quo);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                D_IDLE:  if (i_start) r_state <= D_SCALE;
                D_SCALE: r_state <= D_INIT;
                D_INIT: begin
                    r_cnt   <= '0;
                    r_state <= D_STEP;
                end
                D_STEP: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(QB - 1)) begin
                        r_state <= D_DONE;
                    end
                end
                D_DONE: begin
                    r_done  <= 1'b1;
                    r_state <= D_IDLE;
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    r_neg <= i_pos[POS_W-1];
                    r_mag <= i_pos[POS_W-1] ? POS_W'(-i_pos) : POS_W'(i_pos);
                end
            end
            D_SCALE: begin
                // Times one hundred as 64 + 32 + 4.
                r_num <= (NUM_W'(r_mag) << 6) + (NUM_W'(r_mag) << 5) + (NUM_W'(r_mag) << 2);
            end
            D_INIT: begin
                // Without saturation the upper part is already below the divisor.
                r_sat <= 64'(r_num) >= SAT_LIMIT;
                r_rem <= DIV_W'(r_num >> QB);
            end
            D_STEP: begin
                r_num <= r_num << 1;
                r_quo <= {r_quo[QB-2:0], ge_c};
                r_rem <= ge_c ? DIV_W'(rem2_c - (DIV_W+1)'(DIVISOR)) : DIV_W'(rem2_c);
            end
            D_DONE: begin
                if (r_sat) begin
                    r_val <= r_neg ? drodo_pkg::REP_MIN : drodo_pkg::REP_MAX;
                end else begin
                    r_val <= r_neg ? -quo_ext_c : quo_ext_c;
                end
            end
            default: ;
        endcase
    end

    assign o_done  = r_done;
    assign o_value = r_val;

endmodule

[sv/dead_reckoning_odometry_core.sv]
// Top level of the wheel odometry core: control sequencer, position and heading state.
// Depends on drodo_pkg, drodo_if, drodo_trig, drodo_mul and drodo_div.
//
//  Channel    Direction  Handshake          Carries
//  i_item     in         valid/ready        opcode, left_count, right_count, turn_angle
//  o_result   out        valid/ready        pos_x_hundredths, pos_y_hundredths, heading_deg
//  i_cfg_*    in         write enable only  heading, loaded into the heading register at once
//
// One item at a time. A sample runs through the bit-serial multiplier lanes and the 31-step
// report divider; a commit runs through the multiplier lanes only, and a turn or an unused
// opcode goes straight to the output. Reset is synchronous. A stalled result waits in the
// output register while the next item is taken.
module dead_reckoning_odometry_core #(
    parameter int COUNTS_PER_REV = 360,
    parameter int ENCODER_BITS   = 24,
    parameter int TRIG_FRAC_BITS = 15
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [drodo_pkg::HEAD_W-1:0]   i_cfg_wdata,
    drodo_item_if.sink                     i_item,
    drodo_result_if.source                 o_result
);

    localparam int POS_W  = drodo_pkg::POS_W;
    localparam int REP_W  = drodo_pkg::REP_W;
    localparam int HEAD_W = drodo_pkg::HEAD_W;
    localparam int MAG_W  = TRIG_FRAC_BITS + 1;
    localparam int PROD_W = ENCODER_BITS + TRIG_FRAC_BITS + 1;
    localparam int SUM_W  = ((PROD_W > POS_W) ? PROD_W : POS_W) + 1;
    localparam int WRAP_W = HEAD_W + 2;
    localparam logic signed [WRAP_W-1:0] FULL_TURN_S = WRAP_W'(drodo_pkg::FULL_TURN);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_LOAD   = 7'b0000010,
        S_MUL    = 7'b0000100,
        S_ACC    = 7'b0001000,
        S_DSTART = 7'b0010000,
        S_DWAIT  = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;

    // Wraps a heading sum from -512..870 into 0..359.
    function automatic logic [HEAD_W-1:0] wrap(input logic signed [WRAP_W-1:0] v);
        logic signed [WRAP_W-1:0] s;
        s = v;
        if (s < 0) s = s + FULL_TURN_S;
        if (s < 0) s = s + FULL_TURN_S;
        if (s >= FULL_TURN_S) s = s - FULL_TURN_S;
        if (s >= FULL_TURN_S) s = s - FULL_TURN_S;
        return s[HEAD_W-1:0];
    endfunction

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
        if (v > SUM_W'(drodo_pkg::POS_MAX)) return drodo_pkg::POS_MAX;
        if (v < SUM_W'(drodo_pkg::POS_MIN)) return drodo_pkg::POS_MIN;
        return POS_W'(v);
    endfunction

    t_state                        r_state;
    logic [drodo_pkg::OP_W-1:0]    r_op;
    logic signed [ENCODER_BITS-1:0] r_travel;
    logic [HEAD_W-1:0]             r_heading;
    logic signed [POS_W-1:0]       r_cmt_x;
    logic signed [POS_W-1:0]       r_cmt_y;
    logic signed [POS_W-1:0]       r_prov_x;
    logic signed [POS_W-1:0]       r_prov_y;
    logic signed [REP_W-1:0]       r_rep_x;
    logic signed [REP_W-1:0]       r_rep_y;
    logic                          r_out_valid;
    logic signed [REP_W-1:0]       r_out_x;
    logic signed [REP_W-1:0]       r_out_y;
    logic [HEAD_W-1:0]             r_out_heading;

    logic                          item_accept;
    logic                          out_load;
    logic signed [ENCODER_BITS-1:0] left_c;
    logic signed [ENCODER_BITS-1:0] right_c;
    logic signed [ENCODER_BITS:0]  sum_c;
    logic signed [ENCODER_BITS:0]  adj_c;
    logic signed [WRAP_W-1:0]      turn_sum_c;
    logic signed [SUM_W-1:0]       sum_x_c;
    logic signed [SUM_W-1:0]       sum_y_c;

    logic [MAG_W-1:0]              sin_mag;
    logic                          sin_neg;
    logic [MAG_W-1:0]              cos_mag;
    logic                          cos_neg;
    logic                          mul_start;
    logic                          mul_done_x;
    logic                          mul_done_y;
    logic signed [PROD_W-1:0]      prod_x;
    logic signed [PROD_W-1:0]      prod_y;
    logic                          div_start;
    logic                          div_done_x;
    logic                          div_done_y;
    logic signed [REP_W-1:0]       div_val_x;
    logic signed [REP_W-1:0]       div_val_y;

    assign item_accept  = i_item.valid && (r_state == S_IDLE);
    assign out_load     = (r_state == S_OUT) && (!r_out_valid || o_result.ready);
    assign mul_start    = (r_state == S_LOAD);
    assign div_start    = (r_state == S_DSTART);
    assign i_item.ready = (r_state == S_IDLE);

    always_comb begin
        left_c  = i_item.left_count;
        right_c = i_item.right_count;
        sum_c   = (ENCODER_BITS+1)'(left_c) + (ENCODER_BITS+1)'(right_c);
        // Adding the sign bit before the shift truncates the mean toward zero.
        adj_c   = sum_c + (ENCODER_BITS+1)'(sum_c[ENCODER_BITS]);
        turn_sum_c = $signed({2'b00, r_heading}) + WRAP_W'(i_item.turn_angle);
        sum_x_c = SUM_W'(r_cmt_x) + SUM_W'(prod_x);
        sum_y_c = SUM_W'(r_cmt_y) + SUM_W'(prod_y);
    end

    drodo_trig #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_trig (
        .i_clk     (i_clk),
        .i_heading (r_heading),
        .o_sin_mag (sin_mag),
        .o_sin_neg (sin_neg),
        .o_cos_mag (cos_mag),
        .o_cos_neg (cos_neg)
    );

    // The x step is the negated cosine product.
    drodo_mul #(
        .ENCODER_BITS   (ENCODER_BITS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_mul_x (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_travel  (r_travel),
        .i_mag     (cos_mag),
        .i_neg     (!cos_neg),
        .o_done    (mul_done_x),
        .o_product (prod_x)
    );

    drodo_mul #(
        .ENCODER_BITS   (ENCODER_BITS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_mul_y (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_travel  (r_travel),
        .i_mag     (sin_mag),
        .i_neg     (sin_neg),
        .o_done    (mul_done_y),
        .o_product (prod_y)
    );

    drodo_div #(
        .COUNTS_PER_REV (COUNTS_PER_REV),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_pos   (r_prov_x),
        .o_done  (div_done_x),
        .o_value (div_val_x)
    );

    drodo_div #(
        .COUNTS_PER_REV (COUNTS_PER_REV),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_pos   (r_prov_y),
        .o_done  (div_done_y),
        .o_value (div_val_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_heading   <= HEAD_W'(drodo_pkg::QUARTER_TURN);
            r_cmt_x     <= '0;
            r_cmt_y     <= '0;
            r_prov_x    <= '0;
            r_prov_y    <= '0;
            r_rep_x     <= '0;
            r_rep_y     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                r_heading <= wrap(WRAP_W'(i_cfg_wdata));
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_item.valid) begin
                        unique case (i_item.opcode) inside
                            drodo_pkg::OP_SAMPLE, drodo_pkg::OP_COMMIT: r_state <= S_LOAD;
                            drodo_pkg::OP_TURN: begin
                                r_heading <= wrap(turn_sum_c);
                                r_state   <= S_OUT;
                            end
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_LOAD: r_state <= S_MUL;
                S_MUL: begin
                    if (mul_done_x && mul_done_y) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (r_op == drodo_pkg::OP_SAMPLE) begin
                        r_prov_x <= sat_pos(sum_x_c);
                        r_prov_y <= sat_pos(sum_y_c);
                        r_state  <= S_DSTART;
                    end else begin
                        r_cmt_x <= sat_pos(sum_x_c);
                        r_cmt_y <= sat_pos(sum_y_c);
                        r_state <= S_OUT;
                    end
                end
                S_DSTART: r_state <= S_DWAIT;
                S_DWAIT: begin
                    if (div_done_x && div_done_y) begin
                        r_rep_x <= div_val_x;
                        r_rep_y <= div_val_y;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (item_accept) begin
            r_op     <= i_item.opcode;
            r_travel <= adj_c[ENCODER_BITS:1];
        end
        if (out_load) begin
            r_out_x       <= r_rep_x;
            r_out_y       <= r_rep_y;
            r_out_heading <= r_heading;
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.pos_x_hundredths = r_out_x;
    assign o_result.pos_y_hundredths = r_out_y;
    assign o_result.heading_deg      = r_out_heading;

endmodule

[test/dead_reckoning_odometry_core_test.sv]
// Regression bench for dead_reckoning_odometry_core: directed and random odometry items
// against an in-bench position and heading predictor, checked field by field.
// Depends on drodo_pkg, drodo_if and the core RTL.
module dead_reckoning_odometry_core_test;

    localparam int ENC_W          = 24;
    localparam int COUNTS_PER_REV = 360;
    localparam int TRIG_FRAC      = 15;

    localparam logic [drodo_pkg::OP_W-1:0] OP_UNDEFINED = 2'd3;

    localparam int DEG_QUARTER       = 90;
    localparam int DEG_HALF          = 180;
    localparam int DEG_THREE_QUARTER = 270;
    localparam int DEG_FULL          = 360;
    localparam int RESET_HEADING     = 90;

    localparam longint HUNDREDTHS = 100;
    localparam longint POS_HI     = (longint'(1) <<< 47) - 1;
    localparam longint POS_LO     = -(longint'(1) <<< 47);
    localparam longint REP_HI     = longint'(2147483647);
    localparam longint REP_LO     = -longint'(2147483647) - 1;

    localparam logic signed [ENC_W-1:0] COUNT_MAX = {1'b0, {(ENC_W-1){1'b1}}};
    localparam logic signed [ENC_W-1:0] COUNT_MIN = {1'b1, {(ENC_W-1){1'b0}}};
    localparam logic signed [ENC_W-1:0] COUNT_EDGES [5] = '{
        COUNT_MAX, COUNT_MIN, '0, '1, 24'sd1
    };
    localparam logic signed [drodo_pkg::TURN_W-1:0] TURN_MAX =
        {1'b0, {(drodo_pkg::TURN_W-1){1'b1}}};
    localparam logic signed [drodo_pkg::TURN_W-1:0] TURN_MIN =
        {1'b1, {(drodo_pkg::TURN_W-1){1'b0}}};

    localparam int QUIET_LIMIT = 4000;

    localparam int SINE_Q15 [0:DEG_QUARTER] = '{
        0, 572, 1144, 1715, 2286, 2856, 3425, 3993, 4560, 5126,
        5690, 6252, 6813, 7371, 7927, 8481, 9032, 9580, 10126, 10668,
        11207, 11743, 12275, 12803, 13328, 13848, 14365, 14876, 15384, 15886,
        16384, 16877, 17364, 17847, 18324, 18795, 19261, 19720, 20174, 20622,
        21063, 21498, 21926, 22348, 22763, 23170, 23571, 23965, 24351, 24730,
        25102, 25466, 25822, 26170, 26510, 26842, 27166, 27482, 27789, 28088,
        28378, 28660, 28932, 29197, 29452, 29698, 29935, 30163, 30382, 30592,
        30792, 30983, 31164, 31336, 31499, 31651, 31795, 31928, 32052, 32166,
        32270, 32365, 32449, 32524, 32588, 32643, 32688, 32723, 32748, 32763,
        32768
    };

    typedef struct {
        logic [drodo_pkg::OP_W-1:0]          opcode;
        logic signed [ENC_W-1:0]             left;
        logic signed [ENC_W-1:0]             right;
        logic signed [drodo_pkg::TURN_W-1:0] turn;
        bit                                  hold;
    } t_odo_item;

    typedef struct {
        logic signed [drodo_pkg::REP_W-1:0] x;
        logic signed [drodo_pkg::REP_W-1:0] y;
        logic [drodo_pkg::HEAD_W-1:0]       hdg;
    } t_odo_report;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         cfg_we;
    logic [drodo_pkg::HEAD_W-1:0] cfg_wdata;

    drodo_item_if #(.ENCODER_BITS(ENC_W)) item_ch ();
    drodo_result_if result_ch ();

    dead_reckoning_odometry_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_item      (item_ch),
        .o_result    (result_ch)
    );

    // Predicted odometry state, in counts with TRIG_FRAC fraction bits.
    longint cmt_x = 0;
    longint cmt_y = 0;
    longint prov_x = 0;
    longint prov_y = 0;
    int     head_deg = RESET_HEADING;

    t_odo_item   pending_items[$];
    t_odo_report expected_reports[$];

    bit item_taken = 1'b0;
    bit steady = 1'b0;
    int send_gap = 0;
    int stall_left = 0;
    int error_count = 0;
    int quiet_cycles = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic longint quarter_wave(input int deg);
        return longint'(SINE_Q15[deg]) <<< (TRIG_FRAC - 15);
    endfunction

    function automatic longint sine_of(input int deg);
        int d;
        d = deg % DEG_FULL;
        if (d <= DEG_QUARTER) return quarter_wave(d);
        if (d <= DEG_HALF) return quarter_wave(DEG_HALF - d);
        if (d <= DEG_THREE_QUARTER) return -quarter_wave(d - DEG_HALF);
        return -quarter_wave(DEG_FULL - d);
    endfunction

    function automatic longint clamp_pos(input longint v);
        if (v > POS_HI) return POS_HI;
        if (v < POS_LO) return POS_LO;
        return v;
    endfunction

    function automatic logic signed [drodo_pkg::REP_W-1:0] to_hundredths(input longint pos);
        longint r;
        r = pos * HUNDREDTHS / (longint'(COUNTS_PER_REV) <<< TRIG_FRAC);
        if (r > REP_HI) r = REP_HI;
        else if (r < REP_LO) r = REP_LO;
        return drodo_pkg::REP_W'(r);
    endfunction

    // Advances the predicted state by one item and returns the report it must produce.
    function automatic t_odo_report odometry_step(input t_odo_item it);
        longint travel;
        longint dx;
        longint dy;
        int h;
        travel = (longint'(it.left) + longint'(it.right)) / 2;
        dx = -(travel * sine_of(head_deg + DEG_QUARTER));
        dy = travel * sine_of(head_deg);
        case (it.opcode)
            drodo_pkg::OP_SAMPLE: begin
                prov_x = clamp_pos(cmt_x + dx);
                prov_y = clamp_pos(cmt_y + dy);
            end
            drodo_pkg::OP_COMMIT: begin
                cmt_x = clamp_pos(cmt_x + dx);
                cmt_y = clamp_pos(cmt_y + dy);
            end
            drodo_pkg::OP_TURN: begin
                h = (head_deg + int'(it.turn)) % DEG_FULL;
                if (h < 0) h += DEG_FULL;
                head_deg = h;
            end
            default: ;
        endcase
        return '{x: to_hundredths(prov_x), y: to_hundredths(prov_y),
                 hdg: drodo_pkg::HEAD_W'(head_deg)};
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(30, 120);
    endfunction

    function automatic logic signed [ENC_W-1:0] random_count();
        case ($urandom_range(0, 3))
            0: return ENC_W'($urandom_range(0, 2000) - 1000);
            1: return ENC_W'($urandom);
            2: return ENC_W'($urandom_range(0, 200000) - 100000);
            default: return COUNT_EDGES[$urandom_range(0, 4)];
        endcase
    endfunction

    function automatic t_odo_item random_item();
        t_odo_item it;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35) it.opcode = drodo_pkg::OP_SAMPLE;
        else if (pick < 70) it.opcode = drodo_pkg::OP_COMMIT;
        else if (pick < 90) it.opcode = drodo_pkg::OP_TURN;
        else it.opcode = OP_UNDEFINED;
        it.left = random_count();
        // Half the time the wheels agree closely, as when driving straight.
        if ($urandom_range(0, 1)) it.right = it.left + ENC_W'($urandom_range(0, 64) - 32);
        else it.right = random_count();
        if ($urandom_range(0, 3) == 0) it.turn = drodo_pkg::TURN_W'($urandom);
        else it.turn = drodo_pkg::TURN_W'($urandom_range(0, 2 * DEG_FULL) - DEG_FULL);
        it.hold = ($urandom_range(0, 149) == 0);
        return it;
    endfunction

    // Near-full forward travel, mostly commits, to drive the position into saturation.
    function automatic t_odo_item long_stride_item();
        t_odo_item it;
        it.opcode = ($urandom_range(0, 9) == 0) ? drodo_pkg::OP_SAMPLE : drodo_pkg::OP_COMMIT;
        it.left = COUNT_MAX - ENC_W'($urandom_range(0, 188607));
        it.right = COUNT_MAX - ENC_W'($urandom_range(0, 188607));
        it.turn = drodo_pkg::TURN_W'($urandom);
        it.hold = 1'b0;
        return it;
    endfunction

    function automatic void add_item(input logic [drodo_pkg::OP_W-1:0] op,
                                     input logic signed [ENC_W-1:0] l,
                                     input logic signed [ENC_W-1:0] r,
                                     input logic signed [drodo_pkg::TURN_W-1:0] t);
        pending_items.push_back('{opcode: op, left: l, right: r, turn: t, hold: 1'b0});
    endfunction

    function automatic void queue_items(input int n, input bit stride);
        for (int i = 0; i < n; i++)
            pending_items.push_back(stride ? long_stride_item() : random_item());
    endfunction

    task automatic check_field(input string field, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: %s mismatch: expected %0d, actual %0d",
                     $time, field, want, got);
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || expected_reports.size() > 0 || item_ch.valid)
            @(posedge i_clk);
    endtask

    // The register write loads the heading, so the predictor follows it at once.
    task automatic set_heading(input logic [drodo_pkg::HEAD_W-1:0] value);
        wait_drained();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        head_deg = int'(value) % DEG_FULL;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Item driver: holds each item until its transaction, then idles for a random gap.
    always @(negedge i_clk) begin
        t_odo_item next_item;
        if (!i_rst_n) begin
            item_ch.valid <= 1'b0;
        end else if (!item_ch.valid || item_taken) begin
            item_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                item_ch.valid <= 1'b0;
            end else if (pending_items.size() > 0 &&
                         !(pending_items[0].hold && expected_reports.size() > 0)) begin
                next_item = pending_items.pop_front();
                item_ch.valid <= 1'b1;
                item_ch.opcode <= next_item.opcode;
                item_ch.left_count <= next_item.left;
                item_ch.right_count <= next_item.right;
                item_ch.turn_angle <= next_item.turn;
                send_gap = pick_gap();
            end else begin
                item_ch.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            result_ch.ready <= 1'b0;
        end else begin
            result_ch.ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    // Checks results before predicting the item of the same edge: a result never
    // belongs to an item taken in the same cycle.
    always @(posedge i_clk) begin
        t_odo_item   taken;
        t_odo_report want;
        bit          moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (result_ch.valid && result_ch.ready) begin
                moved = 1'b1;
                if (expected_reports.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result: x %0d, y %0d, heading %0d", $time,
                             result_ch.pos_x_hundredths, result_ch.pos_y_hundredths,
                             result_ch.heading_deg);
                end else begin
                    want = expected_reports.pop_front();
                    check_field("pos_x_hundredths", want.x, result_ch.pos_x_hundredths);
                    check_field("pos_y_hundredths", want.y, result_ch.pos_y_hundredths);
                    check_field("heading_deg", want.hdg, result_ch.heading_deg);
                end
            end
            if (item_ch.valid && item_ch.ready) begin
                moved = 1'b1;
                taken.opcode = item_ch.opcode;
                taken.left = item_ch.left_count;
                taken.right = item_ch.right_count;
                taken.turn = item_ch.turn_angle;
                taken.hold = 1'b0;
                expected_reports.push_back(odometry_step(taken));
                item_taken = 1'b1;
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("dead_reckoning_odometry_core regression: fail");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        item_ch.valid = 1'b0;
        item_ch.opcode = drodo_pkg::OP_SAMPLE;
        item_ch.left_count = '0;
        item_ch.right_count = '0;
        item_ch.turn_angle = '0;
        result_ch.ready = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset heading, count extremes, truncation of the mean toward zero,
        // commit leaving the provisional position alone, the unused opcode, and heading
        // wrap across all quadrants with full-turn and out-of-range angles.
        add_item(drodo_pkg::OP_SAMPLE, 0, 0, 0);
        add_item(drodo_pkg::OP_SAMPLE, COUNT_MAX, COUNT_MAX, 0);
        add_item(drodo_pkg::OP_SAMPLE, COUNT_MIN, COUNT_MIN, 0);
        add_item(drodo_pkg::OP_SAMPLE, COUNT_MAX, COUNT_MIN, 0);
        add_item(drodo_pkg::OP_SAMPLE, 1, 0, 0);
        add_item(drodo_pkg::OP_SAMPLE, -3, 0, 0);
        add_item(drodo_pkg::OP_COMMIT, 1000, 1200, 0);
        add_item(drodo_pkg::OP_SAMPLE, 0, 0, 0);
        add_item(OP_UNDEFINED, COUNT_MAX, COUNT_MAX, 100);
        add_item(drodo_pkg::OP_TURN, 5000, -7, 45);
        add_item(drodo_pkg::OP_SAMPLE, 360, 360, 0);
        add_item(drodo_pkg::OP_TURN, 0, 0, -360);
        add_item(drodo_pkg::OP_TURN, 0, 0, 360);
        add_item(drodo_pkg::OP_TURN, 0, 0, TURN_MIN);
        add_item(drodo_pkg::OP_TURN, 0, 0, TURN_MAX);
        add_item(drodo_pkg::OP_TURN, 0, 0, -134);
        add_item(drodo_pkg::OP_SAMPLE, 7200, 7200, 0);
        add_item(drodo_pkg::OP_TURN, 0, 0, -1);
        add_item(drodo_pkg::OP_COMMIT, COUNT_MAX, COUNT_MAX, 0);
        add_item(drodo_pkg::OP_TURN, 0, 0, 180);
        add_item(drodo_pkg::OP_SAMPLE, -1000, -1000, 0);
        add_item(drodo_pkg::OP_TURN, 0, 0, 91);
        add_item(drodo_pkg::OP_SAMPLE, 500, -300, 0);
        add_item(drodo_pkg::OP_COMMIT, COUNT_MIN, COUNT_MIN, 0);
        add_item(drodo_pkg::OP_SAMPLE, 0, 0, 0);

        set_heading(0);
        queue_items(120, 1'b0);
        set_heading(359);
        steady = 1'b1;
        queue_items(120, 1'b0);
        set_heading(511);
        steady = 1'b0;
        queue_items(120, 1'b0);
        set_heading(360);
        queue_items(100, 1'b0);
        set_heading(drodo_pkg::HEAD_W'($urandom_range(0, 511)));
        queue_items(100, 1'b0);

        // Facing along x, long forward strides push x into negative saturation; after a
        // quarter turn the same strides push y into positive saturation.
        set_heading(0);
        steady = 1'b1;
        queue_items(620, 1'b1);
        add_item(drodo_pkg::OP_TURN, 0, 0, 90);
        wait_drained();
        steady = 1'b0;
        queue_items(620, 1'b1);
        add_item(drodo_pkg::OP_COMMIT, COUNT_MIN, COUNT_MIN, 0);
        add_item(drodo_pkg::OP_SAMPLE, 0, 0, 0);
        add_item(drodo_pkg::OP_COMMIT, COUNT_MIN, COUNT_MIN, 0);
        add_item(drodo_pkg::OP_SAMPLE, COUNT_MIN, COUNT_MIN, 0);
        queue_items(30, 1'b0);

        wait_drained();
        repeat (64) @(posedge i_clk);
        if (error_count == 0) begin
            $display("dead_reckoning_odometry_core regression: pass");
        end else begin
            $display("dead_reckoning_odometry_core regression: fail");
        end
        $finish;
    end

endmodule
